// ===== hdl/cctc_pkg.sv =====
// ----------------------------------------------------------------------------
// cctc_pkg
// Shared types and constants for the cycle count to time converter.
// ----------------------------------------------------------------------------
package cctc_pkg;

  // field widths
  localparam int unsigned CycW   = 64;  // cycle counter samples
  localparam int unsigned FreqW  = 36;  // counter frequency in hertz
  localparam int unsigned TimeW  = 63;  // wall time in 100 ns units
  localparam int unsigned TickW  = 32;  // tick increment
  localparam int unsigned ScaleW = 24;  // width of the 10^7 scale factor
  localparam int unsigned ProdW  = CycW + ScaleW;  // cycles times 10^7
  localparam int unsigned CfgW   = 64;  // config write data
  localparam int unsigned CntW   = 7;   // step counter, holds DivSteps-1

  // iteration counts of the shared serial units
  localparam int unsigned MulSteps = ScaleW;
  localparam int unsigned DivSteps = ProdW;

  // constants
  localparam logic [ScaleW-1:0] UnitsPerSec = ScaleW'(10000000);
  localparam logic [TickW-1:0]  TickDefault = TickW'(100000);
  localparam logic [TickW-1:0]  TickMax     = '1;
  localparam logic [TimeW-1:0]  TimeMax     = '1;

  // config register indexes
  typedef enum logic [1:0] {
    CfgFreq     = 2'd0,
    CfgBootCyc  = 2'd1,
    CfgBootTime = 2'd2
  } cfg_idx_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // take a new input beat
    logic mul_step;  // one shift-add step of the scale multiply
    logic div_step;  // one restoring division step
    logic out_load;  // load the output register
  } cctc_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic bypass;    // item needs no conversion (uncalibrated or invalid)
  } cctc_sts_t;

endpackage

// ===== hdl/cctc_ctrl.sv =====
// ----------------------------------------------------------------------------
// cctc_ctrl
// Sequencer: accepts a beat, runs the serial multiply and divide steps unless
// the beat needs no conversion, then moves the result into the output register.
// ----------------------------------------------------------------------------
module cctc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  cctc_pkg::cctc_sts_t sts_i,
  output cctc_pkg::cctc_cmd_t cmd_o
);
  import cctc_pkg::*;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StMul  = 4'b0010,
    StDiv  = 4'b0100,
    StFin  = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic              accept;
  logic              out_free;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  // next state and commands
  always_comb begin
    state_d         = state_q;
    cnt_d           = cnt_q;
    cmd_o           = '0;
    cmd_o.load      = accept;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (sts_i.bypass) begin
            state_d = StFin;
          end else begin
            state_d = StMul;
            cnt_d   = CntW'(MulSteps - 1);
          end
        end
      end
      StMul: begin
        cmd_o.mul_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = StDiv;
          cnt_d   = CntW'(DivSteps - 1);
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = StFin;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      StFin: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // output beat pending flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hdl/cctc_dpath.sv =====
// ----------------------------------------------------------------------------
// cctc_dpath
// Config registers, tick sample, serial shift-add multiply by 10^7,
// restoring divide by the counter frequency, and result saturation.
// ----------------------------------------------------------------------------
module cctc_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_addr_i,
  input  logic [cctc_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic                          req_type_i,
  input  logic [cctc_pkg::CycW-1:0]     counter_now_i,
  input  cctc_pkg::cctc_cmd_t           cmd_i,
  output cctc_pkg::cctc_sts_t           sts_o,
  output logic [cctc_pkg::TickW-1:0]    tick_increment_o,
  output logic [cctc_pkg::TimeW-1:0]    live_time_o,
  output logic                          time_valid_o
);
  import cctc_pkg::*;

  // config and state
  logic [FreqW-1:0]  freq_q;
  logic [CycW-1:0]   boot_cyc_q;
  logic [TimeW-1:0]  boot_time_q;
  logic [CycW-1:0]   last_tick_q;

  // working registers
  logic              req_q;
  logic              byp_q;
  logic [CycW-1:0]   mcand_q;
  logic [ScaleW-1:0] kshift_q;
  logic [ProdW-1:0]  acc_q;
  logic [FreqW-1:0]  rem_q;

  // output register
  logic [TickW-1:0]  tick_q;
  logic [TimeW-1:0]  live_q;
  logic              valid_q;

  logic              freq_zero;
  logic [CycW-1:0]   base;
  logic [FreqW:0]    rem_sh;
  logic              ge;
  logic [FreqW-1:0]  rem_nxt;
  logic [CycW-1:0]   d_sat;
  logic [TickW-1:0]  tick_sat;
  logic [TimeW+1:0]  live_sum;
  logic [TimeW-1:0]  live_sat;

  assign freq_zero    = (freq_q == '0);
  assign sts_o.bypass = freq_zero || (req_type_i && (boot_time_q == '0));
  assign base         = req_type_i ? boot_cyc_q : last_tick_q;

  // restoring divide step: shift in the next dividend bit, try subtract
  assign rem_sh  = {rem_q, acc_q[ProdW-1]};
  assign ge      = (rem_sh >= {1'b0, freq_q});
  assign rem_nxt = ge ? FreqW'(rem_sh - {1'b0, freq_q}) : rem_sh[FreqW-1:0];

  // saturation of the converted interval and of both results
  assign d_sat    = (|acc_q[ProdW-1:CycW]) ? '1 : acc_q[CycW-1:0];
  assign tick_sat = (|d_sat[CycW-1:TickW]) ? TickMax : d_sat[TickW-1:0];
  assign live_sum = (TimeW+2)'(boot_time_q) + (TimeW+2)'(d_sat);
  assign live_sat = (|live_sum[TimeW+1:TimeW]) ? TimeMax : live_sum[TimeW-1:0];

  // config registers and last tick sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q      <= '0;
      boot_cyc_q  <= '0;
      boot_time_q <= '0;
      last_tick_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgFreq: begin
          freq_q <= cfg_wdata_i[FreqW-1:0];
        end
        CfgBootCyc: begin
          boot_cyc_q  <= cfg_wdata_i[CycW-1:0];
          last_tick_q <= cfg_wdata_i[CycW-1:0];
        end
        CfgBootTime: begin
          boot_time_q <= cfg_wdata_i[TimeW-1:0];
        end
        default: begin
        end
      endcase
    end else if (cmd_i.load && !req_type_i && !freq_zero) begin
      last_tick_q <= counter_now_i;
    end
  end

  // multiply and divide working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q    <= req_type_i;
      byp_q    <= sts_o.bypass;
      mcand_q  <= counter_now_i - base;
      kshift_q <= UnitsPerSec;
      acc_q    <= '0;
      rem_q    <= '0;
    end else if (cmd_i.mul_step) begin
      acc_q    <= (acc_q << 1) + (kshift_q[ScaleW-1] ? ProdW'(mcand_q) : '0);
      kshift_q <= kshift_q << 1;
    end else if (cmd_i.div_step) begin
      acc_q <= {acc_q[ProdW-2:0], ge};
      rem_q <= rem_nxt;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (byp_q) begin
        tick_q  <= req_q ? '0 : TickDefault;
        live_q  <= '0;
        valid_q <= 1'b0;
      end else if (req_q) begin
        tick_q  <= '0;
        live_q  <= live_sat;
        valid_q <= 1'b1;
      end else begin
        tick_q  <= tick_sat;
        live_q  <= '0;
        valid_q <= 1'b0;
      end
    end
  end

  assign tick_increment_o = tick_q;
  assign live_time_o      = live_q;
  assign time_valid_o     = valid_q;

endmodule

// ===== hdl/cycle_count_to_time_converter_unit.sv =====
// ----------------------------------------------------------------------------
// cycle_count_to_time_converter_unit
// Converts cycle counter samples to tick increments and wall time.
// ----------------------------------------------------------------------------
// One item at a time. A tick or query that needs a conversion is taken,
// then runs the serial shift-add multiply by 10^7 and the bit-serial
// restoring divide by counter_frequency; the result is then saturated and
// loaded into the output register once that register is free. An
// uncalibrated tick or an invalid query skips the multiply and divide. The
// next beat is taken as soon as the result sits in the output register,
// even if it has not been taken yet.
module cycle_count_to_time_converter_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write port
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_addr_i,
  input  logic [cctc_pkg::CfgW-1:0]     cfg_wdata_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic [cctc_pkg::CycW-1:0]     counter_now_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [cctc_pkg::TickW-1:0]    tick_increment_o,
  output logic [cctc_pkg::TimeW-1:0]    live_time_o,
  output logic                          time_valid_o
);
  import cctc_pkg::*;

  cctc_cmd_t cmd;
  cctc_sts_t sts;

  // sequencer
  cctc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // arithmetic and registers
  cctc_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .req_type_i       (req_type_i),
    .counter_now_i    (counter_now_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .tick_increment_o (tick_increment_o),
    .live_time_o      (live_time_o),
    .time_valid_o     (time_valid_o)
  );

`ifndef SYNTH
  // a valid query never reports a tick increment
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && time_valid_o |-> tick_increment_o == '0)
    else $error("tick increment set on a valid query");

  // live time is zero whenever it is not valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !time_valid_o |-> live_time_o == '0)
    else $error("live time set without time_valid");

  // a taken beat closes the input in the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after accepting a beat");
`endif

endmodule

// ===== tb/tb_cycle_count_to_time_converter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cycle_count_to_time_converter_unit
// Self-checking bench for the cycle count to time converter. Tick and query
// beats are sent through the valid/ready input channel and every result beat
// is compared against an in-bench predictor of the conversion. Directed cases
// cover the uncalibrated tick, counter wrap, invalid queries, register masking
// and saturation. Random traffic then runs under several config settings and
// idle/stall patterns, including one long output hold-off.
// ----------------------------------------------------------------------------
module tb_cycle_count_to_time_converter_unit;
  import cctc_pkg::*;

  // request codes and the unmapped register slot
  localparam logic       ReqTick   = 1'b0;
  localparam logic       ReqQuery  = 1'b1;
  localparam logic [1:0] CfgUnused = 2'd3;

  localparam logic [63:0] Units64   = 64'(UnitsPerSec);
  localparam int unsigned DrainWait = 150;  // covers a full conversion

  typedef struct packed {
    logic [TickW-1:0] tick;
    logic [TimeW-1:0] live;
    logic             valid;
  } time_result_t;

  // dut ports
  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [1:0]        cfg_addr_i    = '0;
  logic [CfgW-1:0]   cfg_wdata_i   = '0;
  logic              in_valid_i    = 1'b0;
  logic              in_ready_o;
  logic              req_type_i    = ReqTick;
  logic [CycW-1:0]   counter_now_i = '0;
  logic              out_valid_o;
  logic              out_ready_i   = 1'b0;
  logic [TickW-1:0]  tick_increment_o;
  logic [TimeW-1:0]  live_time_o;
  logic              time_valid_o;

  // predictor state
  logic [FreqW-1:0]  cfg_freq      = '0;
  logic [CycW-1:0]   cfg_boot_cyc  = '0;
  logic [TimeW-1:0]  cfg_boot_time = '0;
  logic [CycW-1:0]   last_tick     = '0;

  time_result_t      due_times[$];
  int unsigned       mismatch_cnt  = 0;
  int unsigned       src_idle_pct  = 0;
  int unsigned       sink_stall_pct = 0;
  int unsigned       hold_req      = 0;
  int unsigned       hold_left     = 0;

  cycle_count_to_time_converter_unit i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type_i),
    .counter_now_i    (counter_now_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .tick_increment_o (tick_increment_o),
    .live_time_o      (live_time_o),
    .time_valid_o     (time_valid_o)
  );

  always #5 clk_i = ~clk_i;

  // cycles to 100 ns units, saturating at 2^64-1; f is nonzero
  function automatic logic [63:0] cycles_to_100ns(logic [63:0] dt, logic [FreqW-1:0] f);
    logic [63:0] f64, q, r, part;
    f64  = 64'(f);
    q    = dt / f64;
    r    = dt % f64;
    part = (r * Units64) / f64;  // r < 2^36, product fits
    if (q > (64'hFFFF_FFFF_FFFF_FFFF - part) / Units64) return '1;
    return q * Units64 + part;
  endfunction

  // expected result of one beat; advances the tick sample
  function automatic time_result_t time_of_beat(logic rt, logic [63:0] now);
    time_result_t res;
    logic [63:0]  d;
    res = '0;
    if (rt == ReqTick) begin
      if (cfg_freq == '0) begin
        res.tick = TickDefault;
      end else begin
        d         = cycles_to_100ns(now - last_tick, cfg_freq);
        last_tick = now;
        res.tick  = (d > 64'(TickMax)) ? TickMax : d[TickW-1:0];
      end
    end else if (cfg_boot_time != '0 && cfg_freq != '0) begin
      d = cycles_to_100ns(now - cfg_boot_cyc, cfg_freq);
      if (d >= 64'(TimeMax) - 64'(cfg_boot_time)) res.live = TimeMax;
      else res.live = cfg_boot_time + d[TimeW-1:0];
      res.valid = 1'b1;
    end
    return res;
  endfunction

  // counter sample near the relevant base, with some wild ones mixed in
  function automatic logic [63:0] pick_sample(logic rt);
    logic [63:0] base, span;
    base = (rt == ReqTick) ? last_tick : cfg_boot_cyc;
    span = {$urandom, $urandom} >> $urandom_range(63);
    case ($urandom_range(9))
      0: return {$urandom, $urandom};
      1: return base - span;  // behind the base: wraps to a huge interval
      2: return $urandom_range(1) ? 64'h0 : 64'hFFFF_FFFF_FFFF_FFFF;
      default: return base + span;
    endcase
  endfunction

  // send one beat, keeping valid up across back-to-back beats
  task automatic send_sample(input logic rt, input logic [63:0] now);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i    = 1'b1;
    req_type_i    = rt;
    counter_now_i = now;
    do @(posedge clk_i); while (!in_ready_o);
    due_times.push_back(time_of_beat(rt, now));
  endtask

  // drop valid and wait until every result is back
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (due_times.size() != 0) @(posedge clk_i);
  endtask

  // register write; the dut must be idle
  task automatic write_reg(input logic [1:0] idx, input logic [CfgW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_addr_i  = idx;
    cfg_wdata_i = data;
    case (cfg_idx_e'(idx))
      CfgFreq:     cfg_freq = data[FreqW-1:0];
      CfgBootCyc: begin
        cfg_boot_cyc = data;
        last_tick    = data;
      end
      CfgBootTime: cfg_boot_time = data[TimeW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic randomize_config();
    logic [FreqW-1:0] f;
    logic [TimeW-1:0] bt;
    case ($urandom_range(7))
      0: f = '0;
      1: f = FreqW'(1);
      2: f = '1;
      3: f = {4'($urandom), 32'($urandom)};
      default: f = FreqW'($urandom_range(1_000_000, 32'd4_000_000_000));
    endcase
    case ($urandom_range(5))
      0: bt = '0;
      1: bt = TimeMax;
      default: bt = {31'($urandom), 32'($urandom)};
    endcase
    write_reg(CfgFreq, {28'($urandom), f});
    write_reg(CfgBootCyc, {$urandom, $urandom});
    write_reg(CfgBootTime, {1'($urandom), bt});
    if ($urandom_range(3) == 0) write_reg(CfgUnused, {$urandom, $urandom});
  endtask

  // ticks and queries before calibration
  task automatic test_uncalibrated();
    send_sample(ReqTick, 64'h0);
    send_sample(ReqTick, '1);
    send_sample(ReqQuery, '1);
    wait_idle();
    write_reg(CfgBootTime, {1'b1, 63'd5});  // top bit is dropped
    write_reg(CfgUnused, '1);               // no register here
    send_sample(ReqQuery, 64'h1234);
    send_sample(ReqTick, 64'h0);
  endtask

  // masking, tick sample seeded by boot_cycles, counter wrap
  task automatic test_config_writes();
    wait_idle();
    write_reg(CfgFreq, {28'hFFF_FFFF, 36'd1_000_000});
    write_reg(CfgBootCyc, 64'hFFFF_FFFF_FFFF_FF00);
    send_sample(ReqTick, 64'h100);
    send_sample(ReqQuery, 64'h100);
    wait_idle();
    write_reg(CfgBootTime, '0);
    send_sample(ReqQuery, 64'h100);  // boot time unset
    wait_idle();
    write_reg(CfgFreq, {28'h0, {FreqW{1'b1}}});
    send_sample(ReqTick, '1);
    send_sample(ReqQuery, 64'h0);
  endtask

  // saturation of both outputs and the tick boundary
  task automatic test_saturation();
    wait_idle();
    write_reg(CfgFreq, 64'd1);
    write_reg(CfgBootTime, '1);
    write_reg(CfgBootCyc, 64'h0);
    send_sample(ReqTick, '1);
    send_sample(ReqTick, '1);
    send_sample(ReqQuery, 64'h0);
    send_sample(ReqQuery, '1);
    wait_idle();
    write_reg(CfgBootTime, 64'd1);
    send_sample(ReqQuery, 64'h0);
    send_sample(ReqQuery, 64'd10);
    send_sample(ReqTick, 64'd429);  // just above the tick maximum
    send_sample(ReqTick, 64'd858);  // just below it
  endtask

  // long output hold-off while beats keep coming
  task automatic test_backpressure();
    logic rt;
    wait_idle();
    write_reg(CfgFreq, 64'd1_000_000);
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_req       = 600;
    for (int i = 0; i < 10; i++) begin
      rt = 1'($urandom);
      send_sample(rt, pick_sample(rt));
    end
  endtask

  task automatic test_random_traffic(input int unsigned src_pct, input int unsigned sink_pct,
                                     input int unsigned per_setting);
    logic rt;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    for (int s = 0; s < 3; s++) begin
      wait_idle();
      randomize_config();
      for (int i = 0; i < per_setting; i++) begin
        rt = 1'($urandom);
        send_sample(rt, pick_sample(rt));
      end
    end
  endtask

  // output ready: random stalls, or a counted hold-off
  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i = 1'b0;
    end else begin
      out_ready_i = ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk_i) begin : check_results
    time_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_times.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected beat: tick %0d live %0d valid %0b",
                   tick_increment_o, live_time_o, time_valid_o);
      end else begin
        want = due_times.pop_front();
        if (tick_increment_o !== want.tick || live_time_o !== want.live ||
            time_valid_o !== want.valid) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: tick %0d/%0d live %0d/%0d valid %0b/%0b (exp/got)",
                     want.tick, tick_increment_o, want.live, live_time_o,
                     want.valid, time_valid_o);
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_uncalibrated();
    test_config_writes();
    test_saturation();
    test_backpressure();
    test_random_traffic(0, 0, 146);
    test_random_traffic(64, 0, 146);
    test_random_traffic(0, 64, 146);
    test_random_traffic(18, 18, 146);

    wait_idle();
    repeat (DrainWait) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("[cycle_count_to_time_converter_unit] OK");
    end else begin
      $display("[cycle_count_to_time_converter_unit] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #15_000_000;
    $display("[cycle_count_to_time_converter_unit] ERROR");
    $finish;
  end

endmodule

// ===== cycle_count_to_time_converter_unit.f =====
hdl/cctc_pkg.sv
hdl/cctc_ctrl.sv
hdl/cctc_dpath.sv
hdl/cycle_count_to_time_converter_unit.sv
tb/tb_cycle_count_to_time_converter_unit.sv
